[src/owm_pkg.sv]
// ----------------------------------------------------------------------------
// owm_pkg - shared types and constants of the 1-Wire bus master
// Beat layouts of the command, result and register-write channels, opcodes,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Opcodes of the command channel
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SLOT          = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RECOVERY      = 3'd7;

  // Register reset values (microseconds)
  localparam logic [9:0] RESET_LOW_RST      = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_RST  = 8'd70;
  localparam logic [9:0] RESET_TAIL_RST     = 10'd410;
  localparam logic [3:0] WRITE_ONE_LOW_RST  = 4'd1;
  localparam logic [6:0] WRITE_ZERO_LOW_RST = 7'd60;
  localparam logic [6:0] SLOT_RST           = 7'd60;
  localparam logic [6:0] READ_SAMPLE_RST    = 7'd15;
  localparam logic [3:0] RECOVERY_RST       = 4'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       line_level;
    logic       us_tick;
  } cmd_beat_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } rsp_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_beat_t;

endpackage

[src/owm_cmd_if.sv]
// ----------------------------------------------------------------------------
// owm_cmd_if - command channel of the 1-Wire bus master
// Valid/ready channel carrying one command beat per transfer.
// ----------------------------------------------------------------------------
interface owm_cmd_if import owm_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/owm_rsp_if.sv]
// ----------------------------------------------------------------------------
// owm_rsp_if - result channel of the 1-Wire bus master
// Valid/ready channel carrying one result beat per transfer.
// ----------------------------------------------------------------------------
interface owm_rsp_if import owm_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/owm_cfg_if.sv]
// ----------------------------------------------------------------------------
// owm_cfg_if - register write channel of the 1-Wire bus master
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface owm_cfg_if import owm_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/one_wire_bus_master_core.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master_core - 1-Wire bus master sequencer
// Reset/presence, byte write and byte read sequences timed by a us strobe.
// ----------------------------------------------------------------------------
// One command beat per clock carries an opcode, a write byte, the synchronized
// line level and a one-microsecond strobe; each accepted beat yields exactly
// one result beat with the line drive, busy, done, presence and last read
// byte. The sequencer advances at most one timing phase per accepted beat,
// counting us_tick strobes against the phase length taken from the timing
// registers. Throughput is one beat per clock: the sequencer state updates in
// the accepting cycle and the result lands in a single output register, which
// is refilled in the same cycle it is drained, so ready drops only while a
// result is held by a stalled sink. Opcodes arriving while a command runs are
// ignored. Timing registers should be written only while the block is idle.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core import owm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  owm_cmd_if.sink   in_i,
  owm_rsp_if.source out_o,
  owm_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_RD_WAIT,
    PH_RD_REST
  } phase_e;

  // Timing registers
  logic [9:0] reset_low_q, reset_tail_q;
  logic [7:0] presence_wait_q;
  logic [3:0] write_one_low_q, recovery_q;
  logic [6:0] write_zero_low_q, slot_q, read_sample_q;

  // Sequencer state
  phase_e     phase_q, phase_d;
  logic [9:0] time_cnt_q, time_cnt_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic       presence_q, presence_d;
  logic       is_read_q, is_read_d;
  logic [7:0] last_read_q, last_read_d;
  logic       done;

  // Output register
  logic      out_valid_q;
  rsp_beat_t out_data_q;

  logic      accept;
  cmd_beat_t cmd;

  // Derived phase lengths; negative released times clamp to zero
  logic [6:0] w1_low_ext, slot_minus_w1, sample_minus_w1, sample_pt, slot_minus_sp;
  logic [9:0] phase_len;
  logic [10:0] cnt_inc;
  logic       phase_end;

  assign cmd       = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign w1_low_ext      = {3'b000, write_one_low_q};
  assign slot_minus_w1   = (slot_q > w1_low_ext) ? slot_q - w1_low_ext : 7'd0;
  assign sample_minus_w1 = (read_sample_q > w1_low_ext) ? read_sample_q - w1_low_ext : 7'd0;
  assign sample_pt       = (read_sample_q > w1_low_ext) ? read_sample_q : w1_low_ext;
  assign slot_minus_sp   = (slot_q > sample_pt) ? slot_q - sample_pt : 7'd0;

  always_comb begin
    case (phase_q)
      PH_RST_LOW:  phase_len = reset_low_q;
      PH_RST_WAIT: phase_len = {2'b00, presence_wait_q};
      PH_RST_TAIL: phase_len = reset_tail_q;
      PH_BIT_LOW:  phase_len = (is_read_q || shift_q[0]) ? {6'd0, write_one_low_q}
                                                         : {3'd0, write_zero_low_q};
      PH_BIT_HIGH: phase_len = shift_q[0] ? {3'd0, slot_minus_w1} : {6'd0, recovery_q};
      PH_RD_WAIT:  phase_len = {3'd0, sample_minus_w1};
      PH_RD_REST:  phase_len = {3'd0, slot_minus_sp};
      default:     phase_len = '0;
    endcase
  end

  assign cnt_inc   = {1'b0, time_cnt_q} + 11'd1;
  assign phase_end = (phase_len == '0) || (cmd.us_tick && (cnt_inc >= {1'b0, phase_len}));

  // Next-state logic for one beat
  always_comb begin
    phase_d     = phase_q;
    time_cnt_d  = time_cnt_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    presence_d  = presence_q;
    is_read_d   = is_read_q;
    last_read_d = last_read_q;
    done        = 1'b0;

    if (phase_q == PH_IDLE) begin
      time_cnt_d = '0;
      bit_idx_d  = '0;
      case (cmd.opcode)
        OP_RESET: begin
          is_read_d = 1'b0;
          phase_d   = PH_RST_LOW;
        end
        OP_WRITE: begin
          is_read_d = 1'b0;
          shift_d   = cmd.write_data;
          phase_d   = PH_BIT_LOW;
        end
        OP_READ: begin
          is_read_d = 1'b1;
          shift_d   = '0;
          phase_d   = PH_BIT_LOW;
        end
        default: ;
      endcase
    end else if (phase_end) begin
      time_cnt_d = '0;
      case (phase_q)
        PH_RST_LOW: phase_d = PH_RST_WAIT;
        PH_RST_WAIT: begin
          // low line at the sample point means a device answered
          presence_d = !cmd.line_level;
          if (!cmd.line_level) phase_d = PH_RST_TAIL;
          else done = 1'b1;
        end
        PH_RST_TAIL: done = 1'b1;
        PH_BIT_LOW: phase_d = is_read_q ? PH_RD_WAIT : PH_BIT_HIGH;
        PH_RD_WAIT: begin
          shift_d = {cmd.line_level, shift_q[7:1]};
          phase_d = PH_RD_REST;
        end
        PH_BIT_HIGH, PH_RD_REST: begin
          if (phase_q == PH_BIT_HIGH) shift_d = {1'b0, shift_q[7:1]};
          if (bit_idx_q == 3'd7) begin
            if (is_read_q) last_read_d = shift_q;
            done = 1'b1;
          end else begin
            bit_idx_d = bit_idx_q + 3'd1;
            phase_d   = PH_BIT_LOW;
          end
        end
        default: done = 1'b1;
      endcase
      if (done) begin
        phase_d   = PH_IDLE;
        bit_idx_d = '0;
      end
    end else if (cmd.us_tick) begin
      time_cnt_d = cnt_inc[9:0];
    end
  end

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q      <= RESET_LOW_RST;
      presence_wait_q  <= PRESENCE_WAIT_RST;
      reset_tail_q     <= RESET_TAIL_RST;
      write_one_low_q  <= WRITE_ONE_LOW_RST;
      write_zero_low_q <= WRITE_ZERO_LOW_RST;
      slot_q           <= SLOT_RST;
      read_sample_q    <= READ_SAMPLE_RST;
      recovery_q       <= RECOVERY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_RESET_LOW:      reset_low_q      <= cfg_i.data.value;
        REG_PRESENCE_WAIT:  presence_wait_q  <= cfg_i.data.value[7:0];
        REG_RESET_TAIL:     reset_tail_q     <= cfg_i.data.value;
        REG_WRITE_ONE_LOW:  write_one_low_q  <= cfg_i.data.value[3:0];
        REG_WRITE_ZERO_LOW: write_zero_low_q <= cfg_i.data.value[6:0];
        REG_SLOT:           slot_q           <= cfg_i.data.value[6:0];
        REG_READ_SAMPLE:    read_sample_q    <= cfg_i.data.value[6:0];
        REG_RECOVERY:       recovery_q       <= cfg_i.data.value[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and result register; state moves only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      time_cnt_q  <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      presence_q  <= 1'b0;
      is_read_q   <= 1'b0;
      last_read_q <= '0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      time_cnt_q  <= time_cnt_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
      presence_q  <= presence_d;
      is_read_q   <= is_read_d;
      last_read_q <= last_read_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.drive_low <= (phase_d == PH_RST_LOW) || (phase_d == PH_BIT_LOW);
      out_data_q.busy_res  <= (phase_d != PH_IDLE);
      out_data_q.done_res  <= done;
      out_data_q.presence  <= presence_d;
      out_data_q.read_data <= last_read_d;
    end
  end

endmodule
